/* src/script_token_lexer_top_macros.svh */
// Assertion macros used by the lexer back end.
`ifndef SCRIPT_TOKEN_LEXER_TOP_MACROS_SVH
`define SCRIPT_TOKEN_LEXER_TOP_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define STLX_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Condition never holds.
`define STLX_ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

/* src/stlx_pkg.sv */
// Shared types, constants and helper functions of the lexer.
package stlx_pkg;

   localparam int POS_WIDTH   = 32;
   localparam int LEN_WIDTH   = 16;
   localparam int LINE_WIDTH  = 24;
   localparam int TYPE_WIDTH  = 6;
   localparam int SLOTS       = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);
   localparam int PREFIX_LEN  = 6;

   typedef enum logic [3:0] {
      MODE_IDLE    = 4'd0,
      MODE_SLASH   = 4'd1,
      MODE_COMMENT = 4'd2,
      MODE_OP2     = 4'd3,
      MODE_IDENT   = 4'd4,
      MODE_INT     = 4'd5,
      MODE_DOT     = 4'd6,
      MODE_FRAC    = 4'd7,
      MODE_STRING  = 4'd8
   } mode_type;

   localparam logic [TYPE_WIDTH-1:0] TOK_LPAREN = 6'd0;
   localparam logic [TYPE_WIDTH-1:0] TOK_RPAREN = 6'd1;
   localparam logic [TYPE_WIDTH-1:0] TOK_LBRACE = 6'd2;
   localparam logic [TYPE_WIDTH-1:0] TOK_RBRACE = 6'd3;
   localparam logic [TYPE_WIDTH-1:0] TOK_COMMA  = 6'd4;
   localparam logic [TYPE_WIDTH-1:0] TOK_DOT    = 6'd5;
   localparam logic [TYPE_WIDTH-1:0] TOK_MINUS  = 6'd6;
   localparam logic [TYPE_WIDTH-1:0] TOK_PLUS   = 6'd7;
   localparam logic [TYPE_WIDTH-1:0] TOK_SEMI   = 6'd8;
   localparam logic [TYPE_WIDTH-1:0] TOK_SLASH  = 6'd9;
   localparam logic [TYPE_WIDTH-1:0] TOK_STAR   = 6'd10;
   localparam logic [TYPE_WIDTH-1:0] TOK_BANG   = 6'd11;
   localparam logic [TYPE_WIDTH-1:0] TOK_EQUAL  = 6'd13;
   localparam logic [TYPE_WIDTH-1:0] TOK_GREATER = 6'd15;
   localparam logic [TYPE_WIDTH-1:0] TOK_LESS   = 6'd17;
   localparam logic [TYPE_WIDTH-1:0] TOK_IDENT  = 6'd19;
   localparam logic [TYPE_WIDTH-1:0] TOK_STRING = 6'd20;
   localparam logic [TYPE_WIDTH-1:0] TOK_NUMBER = 6'd21;
   localparam logic [TYPE_WIDTH-1:0] TOK_ERROR  = 6'd38;
   localparam logic [TYPE_WIDTH-1:0] TOK_EOF    = 6'd39;

   localparam logic ERR_UNEXPECTED   = 1'b0;
   localparam logic ERR_UNTERMINATED = 1'b1;

   typedef struct packed {
      logic [TYPE_WIDTH-1:0] token_type;
      logic                  error_kind;
      logic [POS_WIDTH-1:0]  start_offset;
      logic [LEN_WIDTH-1:0]  token_length;
      logic [LINE_WIDTH-1:0] line_number;
   } tok_type;

   typedef struct packed {
      logic [SLOTS-1:0]          valid;
      tok_type [SLOTS-1:0]       slot;
   } bundle_type;

   // keywords, right-justified, first character most significant
   localparam logic [47:0] KW_WORD [16] = '{
      48'("and"), 48'("class"), 48'("else"), 48'("false"),
      48'("for"), 48'("fun"), 48'("if"), 48'("nil"),
      48'("or"), 48'("print"), 48'("return"), 48'("super"),
      48'("this"), 48'("true"), 48'("var"), 48'("while")
   };
   localparam int KW_LEN [16] = '{3, 5, 4, 5, 3, 3, 2, 3, 2, 5, 6, 5, 4, 4, 3, 5};

   function automatic logic [TYPE_WIDTH-1:0] kw_lookup(
      input logic [LEN_WIDTH-1:0] len,
      input logic [PREFIX_LEN-1:0][7:0] pre
   );
      logic [TYPE_WIDTH-1:0] result;
      logic match;
      result = TOK_IDENT;
      for (int k = 0; k < 16; k++) begin
         match = (len == LEN_WIDTH'(KW_LEN[k]));
         for (int i = 0; i < PREFIX_LEN; i++) begin
            if (i < KW_LEN[k]) begin
               if (pre[i] != KW_WORD[k][8*(KW_LEN[k]-1-i) +: 8]) begin
                  match = 1'b0;
               end
            end
         end
         if (match) begin
            result = TYPE_WIDTH'(22 + k);
         end
      end
      return result;
   endfunction

   function automatic logic [POS_WIDTH-1:0] pos_inc(input logic [POS_WIDTH-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic logic [LEN_WIDTH-1:0] len_inc(input logic [LEN_WIDTH-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic logic [LINE_WIDTH-1:0] line_inc(input logic [LINE_WIDTH-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic logic [TYPE_WIDTH-1:0] op_base(input logic [7:0] c);
      logic [TYPE_WIDTH-1:0] t;
      case (c)
         8'h21:   t = TOK_BANG;
         8'h3D:   t = TOK_EQUAL;
         8'h3E:   t = TOK_GREATER;
         default: t = TOK_LESS;
      endcase
      return t;
   endfunction

endpackage

/* src/stlx_front.sv */
// Front end: scans one byte per item and forms a bundle of up to three tokens.
module stlx_front
   import stlx_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic                  kind,
   input  logic [7:0]            char_byte,
   output logic                  push,
   output bundle_type            bundle
);

   mode_type                    mode_ff, mode_in;
   logic [POS_WIDTH-1:0]        pos_ff, pos_in;
   logic [POS_WIDTH-1:0]        tstart_ff, tstart_in;
   logic [LEN_WIDTH-1:0]        tlen_ff, tlen_in;
   logic [LINE_WIDTH-1:0]       line_ff, line_in;
   logic [7:0]                  pending_ff, pending_in;
   logic [PREFIX_LEN-1:0][7:0]  prefix_ff;

   logic       at_end, alpha, digit;
   logic [LEN_WIDTH-1:0] len1, len2;

   // start-of-token decode
   mode_type              sc_mode;
   logic                  sc_emit, sc_start, sc_len1, sc_pend, sc_line;
   logic [TYPE_WIDTH-1:0] sc_type;

   // flush decode
   logic                  use_sc, fl_v, fl_err, dot_v;
   logic [TYPE_WIDTH-1:0] fl_type;
   logic [LEN_WIDTH-1:0]  fl_len;

   logic                  pre_wr;
   logic [2:0]            pre_idx;

   assign at_end = kind || (char_byte == 8'd0);
   assign digit  = (char_byte >= 8'h30) && (char_byte <= 8'h39);
   assign alpha  = ((char_byte >= 8'h61) && (char_byte <= 8'h7A)) ||
                   ((char_byte >= 8'h41) && (char_byte <= 8'h5A)) || (char_byte == 8'h5F);
   assign len1   = len_inc(tlen_ff);
   assign len2   = len_inc(len1);

   always_comb begin
      sc_mode  = MODE_IDLE;
      sc_emit  = 1'b0;
      sc_type  = TOK_ERROR;
      sc_start = 1'b1;
      sc_len1  = 1'b1;
      sc_pend  = 1'b0;
      sc_line  = 1'b0;
      case (char_byte) inside
         8'h20, 8'h0D, 8'h09: begin
            sc_start = 1'b0;
            sc_len1  = 1'b0;
         end
         8'h0A: begin
            sc_start = 1'b0;
            sc_len1  = 1'b0;
            sc_line  = 1'b1;
         end
         8'h28: begin sc_emit = 1'b1; sc_type = TOK_LPAREN; end
         8'h29: begin sc_emit = 1'b1; sc_type = TOK_RPAREN; end
         8'h7B: begin sc_emit = 1'b1; sc_type = TOK_LBRACE; end
         8'h7D: begin sc_emit = 1'b1; sc_type = TOK_RBRACE; end
         8'h2C: begin sc_emit = 1'b1; sc_type = TOK_COMMA; end
         8'h2E: begin sc_emit = 1'b1; sc_type = TOK_DOT; end
         8'h2D: begin sc_emit = 1'b1; sc_type = TOK_MINUS; end
         8'h2B: begin sc_emit = 1'b1; sc_type = TOK_PLUS; end
         8'h3B: begin sc_emit = 1'b1; sc_type = TOK_SEMI; end
         8'h2A: begin sc_emit = 1'b1; sc_type = TOK_STAR; end
         8'h2F: begin
            sc_mode = MODE_SLASH;
            sc_len1 = 1'b0;
         end
         8'h21, 8'h3D, 8'h3C, 8'h3E: begin
            sc_mode = MODE_OP2;
            sc_pend = 1'b1;
            sc_len1 = 1'b0;
         end
         8'h22: sc_mode = MODE_STRING;
         [8'h30:8'h39]: sc_mode = MODE_INT;
         [8'h41:8'h5A], [8'h61:8'h7A], 8'h5F: sc_mode = MODE_IDENT;
         default: sc_emit = 1'b1;
      endcase
      // single-character tokens other than errors leave start and length alone
      if (sc_emit && sc_type != TOK_ERROR) begin
         sc_start = 1'b0;
         sc_len1  = 1'b0;
      end
   end

   always_comb begin
      use_sc  = 1'b0;
      fl_v    = 1'b0;
      fl_err  = ERR_UNEXPECTED;
      fl_type = TOK_NUMBER;
      fl_len  = tlen_ff;
      dot_v   = 1'b0;
      if (at_end) begin
         case (mode_ff)
            MODE_SLASH: begin
               fl_v = 1'b1; fl_type = TOK_SLASH; fl_len = LEN_WIDTH'(1);
            end
            MODE_OP2: begin
               fl_v = 1'b1; fl_type = op_base(pending_ff); fl_len = LEN_WIDTH'(1);
            end
            MODE_IDENT: begin fl_v = 1'b1; fl_type = kw_lookup(tlen_ff, prefix_ff); end
            MODE_INT, MODE_FRAC: fl_v = 1'b1;
            MODE_DOT: begin fl_v = 1'b1; dot_v = 1'b1; end
            MODE_STRING: begin
               fl_v = 1'b1; fl_type = TOK_ERROR; fl_err = ERR_UNTERMINATED;
            end
            default: fl_v = 1'b0;
         endcase
      end else begin
         case (mode_ff)
            MODE_SLASH: if (char_byte != 8'h2F) begin
               fl_v = 1'b1; fl_type = TOK_SLASH; fl_len = LEN_WIDTH'(1); use_sc = 1'b1;
            end
            MODE_COMMENT: use_sc = 1'b0;
            MODE_OP2: begin
               fl_v = 1'b1;
               if (char_byte == 8'h3D) begin
                  fl_type = op_base(pending_ff) + 1'b1;
                  fl_len  = LEN_WIDTH'(2);
               end else begin
                  fl_type = op_base(pending_ff);
                  fl_len  = LEN_WIDTH'(1);
                  use_sc  = 1'b1;
               end
            end
            MODE_IDENT: if (!(alpha || digit)) begin
               fl_v = 1'b1; fl_type = kw_lookup(tlen_ff, prefix_ff); use_sc = 1'b1;
            end
            MODE_INT: if (!digit && char_byte != 8'h2E) begin
               fl_v = 1'b1; use_sc = 1'b1;
            end
            MODE_DOT: if (!digit) begin
               fl_v = 1'b1; dot_v = 1'b1; use_sc = 1'b1;
            end
            MODE_FRAC: if (!digit) begin
               fl_v = 1'b1; use_sc = 1'b1;
            end
            MODE_STRING: if (char_byte == 8'h22) begin
               fl_v = 1'b1; fl_type = TOK_STRING; fl_len = len1;
            end
            default: use_sc = 1'b1;
         endcase
      end
   end

   // next state
   always_comb begin
      mode_in    = mode_ff;
      pos_in     = pos_inc(pos_ff);
      tstart_in  = tstart_ff;
      tlen_in    = tlen_ff;
      line_in    = line_ff;
      pending_in = pending_ff;
      pre_wr     = 1'b0;
      pre_idx    = tlen_ff[2:0];
      if (at_end) begin
         mode_in    = MODE_IDLE;
         pos_in     = '0;
         tstart_in  = '0;
         tlen_in    = '0;
         line_in    = LINE_WIDTH'(1);
         pending_in = 8'd0;
      end else begin
         case (mode_ff)
            MODE_SLASH: if (char_byte == 8'h2F) mode_in = MODE_COMMENT;
            MODE_COMMENT: if (char_byte == 8'h0A) begin
               mode_in = MODE_IDLE;
               line_in = line_inc(line_ff);
            end
            MODE_OP2: mode_in = MODE_IDLE;
            MODE_IDENT: if (alpha || digit) begin
               pre_wr  = (tlen_ff < LEN_WIDTH'(PREFIX_LEN));
               tlen_in = len1;
            end
            MODE_INT: begin
               if (digit) tlen_in = len1;
               else if (char_byte == 8'h2E) mode_in = MODE_DOT;
            end
            MODE_DOT: if (digit) begin
               tlen_in = len2;
               mode_in = MODE_FRAC;
            end
            MODE_FRAC: if (digit) tlen_in = len1;
            MODE_STRING: begin
               tlen_in = len1;
               if (char_byte == 8'h22) mode_in = MODE_IDLE;
               else if (char_byte == 8'h0A) line_in = line_inc(line_ff);
            end
            default: mode_in = MODE_IDLE;
         endcase
         if (use_sc) begin
            mode_in = sc_mode;
            if (sc_start) tstart_in = pos_ff;
            if (sc_len1) tlen_in = LEN_WIDTH'(1);
            if (sc_pend) pending_in = char_byte;
            if (sc_line) line_in = line_inc(line_ff);
            if (sc_mode == MODE_IDENT) begin
               pre_wr  = 1'b1;
               pre_idx = 3'd0;
            end
         end
      end
   end

   // bundle output
   always_comb begin
      bundle.valid[0]              = fl_v;
      bundle.slot[0].token_type    = fl_type;
      bundle.slot[0].error_kind    = fl_err;
      bundle.slot[0].start_offset  = tstart_ff;
      bundle.slot[0].token_length  = fl_len;
      bundle.slot[0].line_number   = line_ff;

      bundle.valid[1]              = dot_v;
      bundle.slot[1].token_type    = TOK_DOT;
      bundle.slot[1].error_kind    = ERR_UNEXPECTED;
      bundle.slot[1].start_offset  = (pos_ff != '0) ? pos_ff - 1'b1 : '0;
      bundle.slot[1].token_length  = LEN_WIDTH'(1);
      bundle.slot[1].line_number   = line_ff;

      bundle.valid[2]              = at_end || (use_sc && sc_emit);
      bundle.slot[2].token_type    = at_end ? TOK_EOF : sc_type;
      bundle.slot[2].error_kind    = ERR_UNEXPECTED;
      bundle.slot[2].start_offset  = pos_ff;
      bundle.slot[2].token_length  = at_end ? LEN_WIDTH'(0) : LEN_WIDTH'(1);
      bundle.slot[2].line_number   = line_ff;

      push = accept && (|bundle.valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         pos_ff     <= '0;
         tstart_ff  <= '0;
         tlen_ff    <= '0;
         line_ff    <= LINE_WIDTH'(1);
         pending_ff <= 8'd0;
      end else if (accept) begin
         mode_ff    <= mode_in;
         pos_ff     <= pos_in;
         tstart_ff  <= tstart_in;
         tlen_ff    <= tlen_in;
         line_ff    <= line_in;
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && pre_wr) begin
         prefix_ff[pre_idx] <= char_byte;
      end
   end

endmodule

/* src/stlx_queue.sv */
// Short queue of token bundles between front and back end.
module stlx_queue
   import stlx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type push_data,
   input  logic       pop,
   output logic       full,
   output logic       empty,
   output bundle_type head
);

   bundle_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]   wr_ff, wr_in;
   logic [QPTR_WIDTH-1:0]   rd_ff, rd_in;
   logic [QCNT_WIDTH-1:0]   count_ff, count_in;

   assign full  = (count_ff == QCNT_WIDTH'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ff];

   always_comb begin
      wr_in    = push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + QCNT_WIDTH'(push) - QCNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

endmodule

/* src/stlx_back.sv */
// Back end: unpacks bundles into single tokens behind an output register.
module stlx_back
   import stlx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  bundle_type head,
   output logic       q_pop,
   input  logic       out_pop,
   output logic       out_valid,
   output tok_type    out_tok,
   output logic       out_last
);

`include "script_token_lexer_top_macros.svh"

   logic [1:0]  slot_ff, slot_in;
   logic        valid_ff, valid_in;
   tok_type     tok_ff;
   logic        last_ff;

   logic        load, sel0, sel1, sel2, more;
   logic [1:0]  sel_idx;
   tok_type     sel_tok;

   always_comb begin
      sel0    = head.valid[0] && (slot_ff == 2'd0);
      sel1    = head.valid[1] && (slot_ff <= 2'd1) && !sel0;
      sel2    = head.valid[2] && !sel0 && !sel1;
      sel_idx = sel0 ? 2'd0 : (sel1 ? 2'd1 : 2'd2);
      sel_tok = head.slot[sel_idx];
      more    = sel0 ? (head.valid[1] || head.valid[2]) : (sel1 ? head.valid[2] : 1'b0);
      load    = !q_empty && (!valid_ff || out_pop);
      q_pop   = load && !more;
      slot_in = slot_ff;
      if (load) begin
         slot_in = more ? sel_idx + 2'd1 : 2'd0;
      end
      valid_in = load ? 1'b1 : (out_pop ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         slot_ff  <= slot_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         tok_ff  <= sel_tok;
         last_ff <= !more;
      end
   end

   assign out_valid = valid_ff;
   assign out_tok   = tok_ff;
   assign out_last  = last_ff;

   `STLX_ASSERT_NEVER(a_slot_range, slot_ff == 2'd3, "slot index out of range")
   `STLX_ASSERT_IMP(a_head_has_token, !q_empty, sel0 || sel1 || sel2, "no token left in head bundle")
   `STLX_ASSERT_IMP(a_pop_resets_slot, q_pop, slot_in == 2'd0, "bundle retired mid-way")

endmodule

/* src/script_token_lexer_top.sv */
// Top level of the streaming script token lexer.
// Takes one source byte per item and returns tokens (punctuators, operators, numbers,
// strings, identifiers, keywords, errors, EOF). An item is taken every cycle while
// the internal bundle queue (four entries) has room; each item yields zero to three
// tokens, and the back end delivers one token per cycle while the receiver pops, so the
// sustained rate is one item per cycle unless items average more than one token. Tokens
// pass through the bundle queue, then the output register. A token that closes on the
// following byte appears with it; the last token of each item has last_of_run set.
module script_token_lexer_top
   import stlx_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic                  req_kind,
   input  logic [7:0]            req_char_byte,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [TYPE_WIDTH-1:0] rsp_token_type,
   output logic                  rsp_error_kind,
   output logic [POS_WIDTH-1:0]  rsp_start_offset,
   output logic [LEN_WIDTH-1:0]  rsp_token_length,
   output logic [LINE_WIDTH-1:0] rsp_line_number,
   output logic                  rsp_last_of_run
);

   logic       accept, f_push, q_full, q_empty, q_pop, out_valid, out_last;
   bundle_type f_bundle, q_head;
   tok_type    out_tok;

   assign accept   = req_push && !q_full;
   assign req_full = q_full;

   stlx_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .kind      (req_kind),
      .char_byte (req_char_byte),
      .push      (f_push),
      .bundle    (f_bundle)
   );

   stlx_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_data (f_bundle),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   stlx_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .head      (q_head),
      .q_pop     (q_pop),
      .out_pop   (rsp_pop),
      .out_valid (out_valid),
      .out_tok   (out_tok),
      .out_last  (out_last)
   );

   assign rsp_empty        = !out_valid;
   assign rsp_token_type   = out_tok.token_type;
   assign rsp_error_kind   = out_tok.error_kind;
   assign rsp_start_offset = out_tok.start_offset;
   assign rsp_token_length = out_tok.token_length;
   assign rsp_line_number  = out_tok.line_number;
   assign rsp_last_of_run  = out_last;

endmodule

/* tb/script_token_lexer_top_test.sv */
// Self-checking testbench for the streaming script token lexer.
`timescale 1ns / 1ps

module script_token_lexer_top_test;
   import stlx_pkg::*;

   typedef struct packed {
      logic       kind;
      logic [7:0] chr;
   } src_item_t;

   typedef struct packed {
      logic [TYPE_WIDTH-1:0] ttype;
      logic                  err;
      logic [POS_WIDTH-1:0]  start;
      logic [LEN_WIDTH-1:0]  len;
      logic [LINE_WIDTH-1:0] line;
      logic                  last;
   } token_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   logic                  req_kind = 1'b0;
   logic [7:0]            req_char_byte = 8'd0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic [TYPE_WIDTH-1:0] rsp_token_type;
   logic                  rsp_error_kind;
   logic [POS_WIDTH-1:0]  rsp_start_offset;
   logic [LEN_WIDTH-1:0]  rsp_token_length;
   logic [LINE_WIDTH-1:0] rsp_line_number;
   logic                  rsp_last_of_run;

   script_token_lexer_top uut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // scanner state mirrored from the spec
   mode_type              sc_mode;
   logic [POS_WIDTH-1:0]  sc_pos, sc_tstart;
   logic [LEN_WIDTH-1:0]  sc_tlen;
   logic [LINE_WIDTH-1:0] sc_line;
   logic [7:0]            sc_prefix [6];
   logic [7:0]            sc_pend;

   src_item_t pending_src[$];
   token_t    expected_tokens[$];
   int        fail_count = 0;
   int        tokens_seen = 0;
   int        items_sent = 0;
   bit        src_done = 1'b0;
   bit        hold_long = 1'b0;
   int        type_hits [40];

   function automatic bit is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic [LEN_WIDTH-1:0] sat_len(logic [LEN_WIDTH-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic logic [TYPE_WIDTH-1:0] cmp_op(logic [7:0] c);
      case (c)
         "!": return TOK_BANG;
         "=": return TOK_EQUAL;
         ">": return TOK_GREATER;
         default: return TOK_LESS;
      endcase
   endfunction

   function automatic logic [TYPE_WIDTH-1:0] word_class();
      string words [16] = '{"and", "class", "else", "false", "for", "fun", "if", "nil",
                            "or", "print", "return", "super", "this", "true", "var",
                            "while"};
      bit hit;
      for (int k = 0; k < 16; k++) begin
         if (sc_tlen == words[k].len()) begin
            hit = 1'b1;
            for (int i = 0; i < words[k].len(); i++)
               if (sc_prefix[i] != words[k][i]) hit = 1'b0;
            if (hit) return TYPE_WIDTH'(22 + k);
         end
      end
      return TOK_IDENT;
   endfunction

   task automatic add_token(logic [TYPE_WIDTH-1:0] t, logic e,
                            logic [POS_WIDTH-1:0] s, logic [LEN_WIDTH-1:0] l);
      token_t tk;
      tk.ttype = t; tk.err = e; tk.start = s; tk.len = l; tk.line = sc_line;
      tk.last = 1'b0;
      expected_tokens.push_back(tk);
   endtask

   task automatic scanner_reset();
      sc_mode = MODE_IDLE; sc_pos = '0; sc_tstart = '0; sc_tlen = '0;
      sc_line = 1; sc_pend = 8'd0;
      foreach (sc_prefix[i]) sc_prefix[i] = 8'd0;
   endtask

   task automatic begin_token(logic [7:0] c);
      sc_mode = MODE_IDLE;
      case (c)
         " ", 8'h0D, "\t": ;
         "\n": sc_line = (&sc_line) ? sc_line : sc_line + 1'b1;
         "(": add_token(TOK_LPAREN, 1'b0, sc_pos, 1);
         ")": add_token(TOK_RPAREN, 1'b0, sc_pos, 1);
         "{": add_token(TOK_LBRACE, 1'b0, sc_pos, 1);
         "}": add_token(TOK_RBRACE, 1'b0, sc_pos, 1);
         ",": add_token(TOK_COMMA, 1'b0, sc_pos, 1);
         ".": add_token(TOK_DOT, 1'b0, sc_pos, 1);
         "-": add_token(TOK_MINUS, 1'b0, sc_pos, 1);
         "+": add_token(TOK_PLUS, 1'b0, sc_pos, 1);
         ";": add_token(TOK_SEMI, 1'b0, sc_pos, 1);
         "*": add_token(TOK_STAR, 1'b0, sc_pos, 1);
         "/": begin
            sc_mode = MODE_SLASH; sc_tstart = sc_pos;
         end
         "!", "=", "<", ">": begin
            sc_mode = MODE_OP2; sc_pend = c; sc_tstart = sc_pos;
         end
         "\"": begin
            sc_mode = MODE_STRING; sc_tstart = sc_pos; sc_tlen = 1;
         end
         default: begin
            sc_tstart = sc_pos; sc_tlen = 1;
            if (is_alpha(c)) begin
               sc_mode = MODE_IDENT; sc_prefix[0] = c;
            end else if (is_digit(c)) begin
               sc_mode = MODE_INT;
            end else begin
               add_token(TOK_ERROR, ERR_UNEXPECTED, sc_pos, 1);
            end
         end
      endcase
   endtask

   // works out the tokens that one source item produces
   task automatic scan_item(src_item_t it);
      int before_n;
      logic [POS_WIDTH-1:0] dot_at;
      before_n = expected_tokens.size();
      dot_at = (sc_pos > 0) ? sc_pos - 1'b1 : '0;
      if (it.kind || it.chr == 8'd0) begin
         case (sc_mode)
            MODE_SLASH: add_token(TOK_SLASH, 1'b0, sc_tstart, 1);
            MODE_OP2: add_token(cmp_op(sc_pend), 1'b0, sc_tstart, 1);
            MODE_IDENT: add_token(word_class(), 1'b0, sc_tstart, sc_tlen);
            MODE_INT, MODE_FRAC: add_token(TOK_NUMBER, 1'b0, sc_tstart, sc_tlen);
            MODE_DOT: begin
               add_token(TOK_NUMBER, 1'b0, sc_tstart, sc_tlen);
               add_token(TOK_DOT, 1'b0, dot_at, 1);
            end
            MODE_STRING: add_token(TOK_ERROR, ERR_UNTERMINATED, sc_tstart, sc_tlen);
            default: ;
         endcase
         add_token(TOK_EOF, 1'b0, sc_pos, 0);
         scanner_reset();
      end else begin
         case (sc_mode)
            MODE_SLASH:
               if (it.chr == "/") sc_mode = MODE_COMMENT;
               else begin
                  add_token(TOK_SLASH, 1'b0, sc_tstart, 1);
                  begin_token(it.chr);
               end
            MODE_COMMENT:
               if (it.chr == "\n") begin
                  sc_line = (&sc_line) ? sc_line : sc_line + 1'b1;
                  sc_mode = MODE_IDLE;
               end
            MODE_OP2:
               if (it.chr == "=") begin
                  add_token(cmp_op(sc_pend) + 1'b1, 1'b0, sc_tstart, 2);
                  sc_mode = MODE_IDLE;
               end else begin
                  add_token(cmp_op(sc_pend), 1'b0, sc_tstart, 1);
                  begin_token(it.chr);
               end
            MODE_IDENT:
               if (is_alpha(it.chr) || is_digit(it.chr)) begin
                  if (sc_tlen < 6) sc_prefix[sc_tlen] = it.chr;
                  sc_tlen = sat_len(sc_tlen);
               end else begin
                  add_token(word_class(), 1'b0, sc_tstart, sc_tlen);
                  begin_token(it.chr);
               end
            MODE_INT:
               if (is_digit(it.chr)) sc_tlen = sat_len(sc_tlen);
               else if (it.chr == ".") sc_mode = MODE_DOT;
               else begin
                  add_token(TOK_NUMBER, 1'b0, sc_tstart, sc_tlen);
                  begin_token(it.chr);
               end
            MODE_DOT:
               if (is_digit(it.chr)) begin
                  sc_tlen = sat_len(sat_len(sc_tlen));
                  sc_mode = MODE_FRAC;
               end else begin
                  add_token(TOK_NUMBER, 1'b0, sc_tstart, sc_tlen);
                  add_token(TOK_DOT, 1'b0, dot_at, 1);
                  begin_token(it.chr);
               end
            MODE_FRAC:
               if (is_digit(it.chr)) sc_tlen = sat_len(sc_tlen);
               else begin
                  add_token(TOK_NUMBER, 1'b0, sc_tstart, sc_tlen);
                  begin_token(it.chr);
               end
            MODE_STRING: begin
               sc_tlen = sat_len(sc_tlen);
               if (it.chr == "\"") begin
                  add_token(TOK_STRING, 1'b0, sc_tstart, sc_tlen);
                  sc_mode = MODE_IDLE;
               end else if (it.chr == "\n") begin
                  sc_line = (&sc_line) ? sc_line : sc_line + 1'b1;
               end
            end
            default: begin_token(it.chr);
         endcase
         if (!(&sc_pos)) sc_pos = sc_pos + 1'b1;
      end
      if (expected_tokens.size() > before_n)
         expected_tokens[$].last = 1'b1;
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) pending_src.push_back({1'b0, s[i]});
   endtask

   task automatic add_end();
      pending_src.push_back({1'b1, 8'($urandom)});
   endtask

   function automatic string pick_snippet();
      string snippets [28] = '{"and", "class", "else", "false", "for", "fun", "if", "nil",
                               "or", "print", "return", "super", "this", "true", "var",
                               "while", "foo_1", "Returned", "x", "123", "3.14", "7.",
                               "\"hi\"", "\"a\nb\"", "!=", "==", "<=", ">="};
      string singles = "(){},.-+;*/!=<>";
      string s;
      case ($urandom_range(0, 5))
         0, 1, 2: s = snippets[$urandom_range(0, 27)];
         3: s = string'(singles[$urandom_range(0, singles.len() - 1)]);
         4: s = "// note\n";
         default: s = " ";
      endcase
      return s;
   endfunction

   initial begin
      int prog_len;
      scanner_reset();
      foreach (type_hits[i]) type_hits[i] = 0;
      // directed: every punctuator, operators, keywords, number forms, errors
      add_text("(){},.-+;*/ ! != = == < <= > >=\t");
      pending_src.push_back({1'b0, 8'h0D});
      add_text("\n");
      add_end();
      add_text("and class else false for fun if nil or print return super this true var while");
      add_end();
      add_text("x1 _Ab9Zz 0 9.5 12.a 3.\n// c\n\"s\nx\" @");
      pending_src.push_back({1'b0, 8'h80});
      pending_src.push_back({1'b0, 8'hFF});
      add_text("/ !");
      add_end();
      add_text("\"open");
      add_end();
      add_text("5.");
      add_end();
      add_text("ab");
      pending_src.push_back({1'b0, 8'h00});
      add_text("<");
      add_end();
      add_text("/");
      add_end();
      add_text("classy");
      add_end();
      // random: mostly well-formed programs, some raw byte noise
      while (pending_src.size() < 2000 && items_sent == 0 && pending_src.size() < 340) begin
         prog_len = $urandom_range(2, 12);
         for (int i = 0; i < prog_len; i++) begin
            if ($urandom_range(0, 9) == 0)
               pending_src.push_back({1'b0, 8'($urandom_range(1, 255))});
            else
               add_text(pick_snippet());
            if ($urandom_range(0, 2) == 0) add_text(" ");
         end
         if ($urandom_range(0, 3) != 0) add_end();
      end
      add_end();
      src_done = 1'b1;
   end

   // sender: bursts with random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            scan_item({req_kind, req_char_byte});
            items_sent <= items_sent + 1;
         end
         if (req_push && req_full) begin
            // keep offering the same item
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_push <= 1'b0;
         end else if (pending_src.size() > 0) begin
            src_item_t it;
            it = pending_src.pop_front();
            req_kind <= it.kind;
            req_char_byte <= it.chr;
            req_push <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 30);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // receiver: stall pattern with one long hold-off
   int rx_cycle = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         rx_cycle <= rx_cycle + 1;
         hold_long <= (rx_cycle >= 200 && rx_cycle < 320);
         if (rx_cycle >= 200 && rx_cycle < 320)
            rsp_pop <= 1'b0;
         else if (rx_cycle % 1000 < 300)
            rsp_pop <= 1'b1;
         else
            rsp_pop <= ($urandom_range(0, 3) != 0);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         token_t got, want;
         got = {rsp_token_type, rsp_error_kind, rsp_start_offset, rsp_token_length,
                rsp_line_number, rsp_last_of_run};
         tokens_seen <= tokens_seen + 1;
         if (expected_tokens.size() == 0) begin
            $display("%0t: unexpected token, got %p", $time, got);
            fail_count <= fail_count + 1;
         end else begin
            want = expected_tokens.pop_front();
            if (rsp_token_type < 40) type_hits[rsp_token_type]++;
            if (got != want) begin
               $display("%0t: token mismatch, expected %p, actual %p", $time, want, got);
               fail_count <= fail_count + 1;
            end
         end
      end
   end

   // watchdog and end of run
   initial begin
      int idle_cycles;
      int covered;
      idle_cycles = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (!(src_done && pending_src.size() == 0 && !req_push
               && expected_tokens.size() == 0) && idle_cycles < 5000) begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_cycles = 0;
         else idle_cycles++;
      end
      repeat (20) @(posedge clock);
      covered = 0;
      foreach (type_hits[i]) if (type_hits[i] > 0) covered++;
      $display("Run covered %0d source items and %0d tokens, %0d of 40 token classes.",
               items_sent, tokens_seen, covered);
      if (idle_cycles >= 5000) begin
         $display("Timeout with %0d tokens outstanding", expected_tokens.size());
         $display("Mismatches found");
      end else if (fail_count == 0 && expected_tokens.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
